[rtl/core/ipv4lpm_pkg.sv]
package ipv4lpm_pkg;

  // Table geometry
  localparam int unsigned TableEntriesDef = 64;
  localparam int unsigned AddrW           = 32;
  localparam int unsigned LenW            = 6;
  localparam logic [LenW-1:0] MaxLen      = 6'd32;

  // Stream widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned CountW   = 7;

  // Configuration register indexes
  localparam logic RegAllowDup  = 1'b0;
  localparam logic RegRemoveAll = 1'b1;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_LOOKUP   = 3'd2,
    OP_CONTAINS = 3'd3,
    OP_COVERED  = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_NOTHING = 2'd3
  } status_e;

  // One table slot
  typedef struct packed {
    logic             valid;
    logic [LenW-1:0]  len;
    logic [AddrW-1:0] addr;
  } entry_t;

  // Verdict of the shared compare unit on one slot
  typedef struct packed {
    logic eq;   // valid and equal to the masked query prefix
    logic pfx;  // valid and matching the raw query address
    logic cov;  // prefix hit and no longer than the query
  } match_t;

  // Top len bits set; len is already saturated to 32
  function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    m = '0;
    if (len != '0) begin
      m = {AddrW{1'b1}} << (MaxLen - len);
    end
    return m;
  endfunction

endpackage

[rtl/core/ipv4lpm_table.sv]
module ipv4lpm_table #(
  parameter int unsigned TABLE_ENTRIES = ipv4lpm_pkg::TableEntriesDef,
  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IdxW-1:0]     waddr_i,
  input  ipv4lpm_pkg::entry_t wdata_i,
  input  logic                re_i,
  input  logic [IdxW-1:0]     raddr_i,
  output ipv4lpm_pkg::entry_t rdata_o
);

  ipv4lpm_pkg::entry_t mem_q [TABLE_ENTRIES];
  ipv4lpm_pkg::entry_t rdata_q;

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/ipv4lpm_match.sv]
module ipv4lpm_match (
  input  ipv4lpm_pkg::entry_t                    entry_i,
  input  logic [ipv4lpm_pkg::AddrW-1:0]          raw_i,
  input  logic [ipv4lpm_pkg::AddrW-1:0]          qaddr_i,
  input  logic [ipv4lpm_pkg::LenW-1:0]           qlen_i,
  output ipv4lpm_pkg::match_t                    match_o
);

  logic [ipv4lpm_pkg::AddrW-1:0] mask;
  logic                          hit;

  // Mask the query by the slot length; for a slot no longer than the query
  // the raw and the masked query agree on those bits
  assign mask = ipv4lpm_pkg::len_mask(entry_i.len);
  assign hit  = entry_i.valid && ((raw_i & mask) == entry_i.addr);

  assign match_o.eq  = entry_i.valid && (entry_i.addr == qaddr_i) && (entry_i.len == qlen_i);
  assign match_o.pfx = hit;
  assign match_o.cov = hit && (entry_i.len <= qlen_i);

endmodule

[rtl/core/ipv4_prefix_table_lpm_unit.sv]
// Channel   | Direction | Handshake                    | Payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser op; tdata address, length
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata found .. entry_count
// cfg       | in        | cfg_we_i                     | cfg_idx_i, cfg_wdata_i
//
// Insert, remove, lookup, contains and covered scan the slot memory one slot
// per cycle through a single read port. Clear sweeps the memory one slot per
// cycle. Unused op codes skip the scan and go straight to the result. After
// reset a sweep marks every slot invalid before the first word is taken.
// The result register holds a word while m_axis_tready is low; the next word
// is taken meanwhile and waits at the end of its scan.
module ipv4_prefix_table_lpm_unit #(
  parameter int unsigned TABLE_ENTRIES = ipv4lpm_pkg::TableEntriesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Fields from bit 0: prefix_address[31:0], prefix_len[37:32], zero fill
  input  logic [ipv4lpm_pkg::InDataW-1:0]     s_axis_tdata,
  // Fields from bit 0: op[2:0]
  input  logic [ipv4lpm_pkg::InUserW-1:0]     s_axis_tuser,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0: found[0], match_address[32:1], match_length[38:33],
  // status[40:39], entry_count[47:41]
  output logic [ipv4lpm_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic                                cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned CW   = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntEnd  = CntW'(TABLE_ENTRIES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_WIPE = 4'b0001,
    S_IDLE = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e                          state_q, state_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            p_vld_q, p_vld_d;
  logic [IdxW-1:0]                 p_idx_q, p_idx_d;
  logic                            init_q, init_d;
  logic [CW-1:0]                   count_q, count_d;
  logic                            allow_dup_q, rm_all_q;
  logic                            found_q, found_d;
  logic [ipv4lpm_pkg::AddrW-1:0]   best_addr_q, best_addr_d;
  logic [ipv4lpm_pkg::LenW-1:0]    best_len_q, best_len_d;
  logic                            dup_q, dup_d;
  logic                            removed_q, removed_d;
  logic                            free_vld_q, free_vld_d;
  logic [IdxW-1:0]                 free_idx_q, free_idx_d;
  logic                            out_vld_q, out_vld_d;
  logic [ipv4lpm_pkg::OutDataW-1:0] out_data_q, out_data_d;

  // Query payload, loaded on accept
  ipv4lpm_pkg::op_e                op_q;
  logic [ipv4lpm_pkg::AddrW-1:0]   raw_q, qaddr_q;
  logic [ipv4lpm_pkg::LenW-1:0]    qlen_q;
  logic [ipv4lpm_pkg::LenW-1:0]    in_len;
  logic                            in_acc;

  logic                            mem_we, mem_re;
  logic [IdxW-1:0]                 mem_waddr, mem_raddr;
  ipv4lpm_pkg::entry_t             mem_wdata, mem_rdata;
  ipv4lpm_pkg::match_t             hit;
  ipv4lpm_pkg::status_e            status;
  logic                            out_free;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign in_len        = (s_axis_tdata[37:32] > ipv4lpm_pkg::MaxLen) ?
                         ipv4lpm_pkg::MaxLen : s_axis_tdata[37:32];

  ipv4lpm_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  ipv4lpm_match u_match (
    .entry_i(mem_rdata),
    .raw_i  (raw_q),
    .qaddr_i(qaddr_q),
    .qlen_i (qlen_q),
    .match_o(hit)
  );

  // Latch the query
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= ipv4lpm_pkg::op_e'(s_axis_tuser);
      raw_q   <= s_axis_tdata[31:0];
      qlen_q  <= in_len;
      qaddr_q <= s_axis_tdata[31:0] & ipv4lpm_pkg::len_mask(in_len);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_dup_q <= 1'b0;
      rm_all_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ipv4lpm_pkg::RegAllowDup:  allow_dup_q <= cfg_wdata_i;
        ipv4lpm_pkg::RegRemoveAll: rm_all_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    p_vld_d     = 1'b0;
    p_idx_d     = p_idx_q;
    init_d      = init_q;
    count_d     = count_q;
    found_d     = found_q;
    best_addr_d = best_addr_q;
    best_len_d  = best_len_q;
    dup_d       = dup_q;
    removed_d   = removed_q;
    free_vld_d  = free_vld_q;
    free_idx_d  = free_idx_q;
    out_vld_d   = out_vld_q && !m_axis_tready;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = p_idx_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = cnt_q[IdxW-1:0];
    status      = ipv4lpm_pkg::ST_DONE;

    unique case (state_q)
      S_WIPE: begin
        // Invalidate one slot a cycle
        mem_we    = 1'b1;
        mem_waddr = cnt_q[IdxW-1:0];
        cnt_d     = cnt_q + 1'b1;
        if (cnt_q[IdxW-1:0] == LastIdx) begin
          count_d = '0;
          init_d  = 1'b0;
          state_d = init_q ? S_IDLE : S_FIN;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          cnt_d       = '0;
          found_d     = 1'b0;
          best_addr_d = '0;
          best_len_d  = '0;
          dup_d       = 1'b0;
          removed_d   = 1'b0;
          free_vld_d  = 1'b0;
          if (s_axis_tuser == ipv4lpm_pkg::OP_CLEAR) begin
            state_d = S_WIPE;
          end else if (s_axis_tuser <= ipv4lpm_pkg::OP_COVERED) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_FIN;
          end
        end
      end

      S_SCAN: begin
        // Issue the next read
        if (cnt_q != CntEnd) begin
          mem_re  = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          p_vld_d = 1'b1;
          p_idx_d = cnt_q[IdxW-1:0];
        end
        // Judge the slot read last cycle
        if (p_vld_q) begin
          unique case (op_q)
            ipv4lpm_pkg::OP_INSERT: begin
              if (hit.eq) begin
                dup_d = 1'b1;
              end
              if (!mem_rdata.valid && !free_vld_q) begin
                free_vld_d = 1'b1;
                free_idx_d = p_idx_q;
              end
            end
            ipv4lpm_pkg::OP_REMOVE: begin
              if (hit.eq && (rm_all_q || !removed_q)) begin
                mem_we    = 1'b1;
                removed_d = 1'b1;
                if (count_q != '0) begin
                  count_d = count_q - 1'b1;
                end
              end
            end
            ipv4lpm_pkg::OP_LOOKUP: begin
              if (hit.pfx && (!found_q || (mem_rdata.len > best_len_q))) begin
                found_d     = 1'b1;
                best_addr_d = mem_rdata.addr;
                best_len_d  = mem_rdata.len;
              end
            end
            ipv4lpm_pkg::OP_CONTAINS: begin
              if (hit.eq) begin
                found_d = 1'b1;
              end
            end
            ipv4lpm_pkg::OP_COVERED: begin
              if (hit.cov) begin
                found_d = 1'b1;
              end
            end
            default: ;
          endcase
          if (p_idx_q == LastIdx) begin
            state_d = S_FIN;
          end
        end
      end

      S_FIN: begin
        // Wait for a free result register, then commit
        if (out_free) begin
          unique case (op_q)
            ipv4lpm_pkg::OP_INSERT: begin
              if (!allow_dup_q && dup_q) begin
                status = ipv4lpm_pkg::ST_DUP;
              end else if (!free_vld_q) begin
                status = ipv4lpm_pkg::ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = free_idx_q;
                mem_wdata.valid = 1'b1;
                mem_wdata.len   = qlen_q;
                mem_wdata.addr  = qaddr_q;
                count_d         = count_q + 1'b1;
              end
            end
            ipv4lpm_pkg::OP_REMOVE: begin
              status = removed_q ? ipv4lpm_pkg::ST_DONE : ipv4lpm_pkg::ST_NOTHING;
            end
            default: ;
          endcase
          out_vld_d  = 1'b1;
          out_data_d = {ipv4lpm_pkg::CountW'(count_d), status, best_len_q, best_addr_q,
                        found_q};
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_WIPE;
      cnt_q      <= '0;
      p_vld_q    <= 1'b0;
      init_q     <= 1'b1;
      count_q    <= '0;
      found_q    <= 1'b0;
      dup_q      <= 1'b0;
      removed_q  <= 1'b0;
      free_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      p_vld_q    <= p_vld_d;
      init_q     <= init_d;
      count_q    <= count_d;
      found_q    <= found_d;
      dup_q      <= dup_d;
      removed_q  <= removed_d;
      free_vld_q <= free_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    p_idx_q     <= p_idx_d;
    best_addr_q <= best_addr_d;
    best_len_q  <= best_len_d;
    free_idx_q  <= free_idx_d;
    out_data_q  <= out_data_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/core/ipv4lpm_checker.sv]
module ipv4lpm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic [ipv4lpm_pkg::InDataW-1:0]  s_axis_tdata,
  input logic [ipv4lpm_pkg::InUserW-1:0]  s_axis_tuser,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [ipv4lpm_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word changed while stalled");

  // Hold an offered input word until it is taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input word changed while waiting");

  // One operation at a time: drop ready after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken during an operation");

  // A success never carries a failure status
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[40:39] == ipv4lpm_pkg::ST_DONE)
    else $error("found with non-zero status");

  // No match gives a zero address and length
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[38:1] == '0)
    else $error("match fields set without a match");

endmodule

bind ipv4_prefix_table_lpm_unit ipv4lpm_checker u_ipv4lpm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);
